@@ design/tcst_pkg.sv @@
// package for the trouble code status table
// types, op codes, status bit constants and controller state type; no dependencies
package tcst_pkg;

    localparam int TABLE_SLOTS_DEF    = 32;
    localparam int SNAPSHOT_BYTES_DEF = 8;

    typedef enum logic [2:0] {
        OP_INIT      = 3'd0,
        OP_FAILED    = 3'd1,
        OP_PASSED    = 3'd2,
        OP_CLEAR_ONE = 3'd3,
        OP_CLEAR_ALL = 3'd4,
        OP_AGE       = 3'd5,
        OP_QUERY     = 3'd6,
        OP_BAD       = 3'd7
    } op_t;

    localparam logic [7:0] ST_FAILED         = 8'h01;
    localparam logic [7:0] ST_FAILED_CYCLE   = 8'h02;
    localparam logic [7:0] ST_PENDING        = 8'h04;
    localparam logic [7:0] ST_CONFIRMED      = 8'h08;
    localparam logic [7:0] ST_NOT_DONE_CLEAR = 8'h10;
    localparam logic [7:0] ST_FAILED_CLEAR   = 8'h20;
    localparam logic [7:0] ST_NOT_DONE_CYCLE = 8'h40;
    localparam logic [7:0] ST_IDLE           = 8'h50;

    localparam logic [7:0]  AGE_MAX = 8'hFF;
    localparam logic [15:0] OCC_MAX = 16'hFFFF;
    localparam logic [7:0]  AGING_RESET = 8'd40;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_COUNT,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input transfer, clear scan index
        logic step;       // advance scan index
        logic apply;      // perform the op on scan results
        logic cnt_clear;  // restart active count
        logic cnt_step;   // count one slot
        logic out_load;   // load the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic busy_op;    // op needs a scan
    } dp_stat_t;

endpackage

@@ design/tcst_ctrl.sv @@
// controller state machine for the trouble code status table
// uses tcst_pkg; drives the datapath by command struct
module tcst_ctrl
    import tcst_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // only ops that need a scan walk the table here; the others go straight to apply
                if (stat.scan_last || !stat.busy_op) begin
                    state_next = S_APPLY;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_APPLY: begin
                cmd.apply     = 1'b1;
                cmd.cnt_clear = 1'b1;
                state_next    = S_COUNT;
            end
            S_COUNT: begin
                cmd.cnt_step = 1'b1;
                cmd.step     = 1'b1;
                if (stat.scan_last) state_next = S_DONE;
            end
            S_DONE: begin
                // output register may still hold an earlier result
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_ready)
        else $error("accept while busy");
    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_SCAN)
        else $error("load without scan");

endmodule

@@ design/tcst_dp.sv @@
// datapath for the trouble code status table: slot registers, scan index,
// find and allocate search, op execution and result register; uses tcst_pkg
module tcst_dp
    import tcst_pkg::*;
#(
    parameter int TABLE_SLOTS    = TABLE_SLOTS_DEF,
    parameter int SNAPSHOT_BYTES = SNAPSHOT_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [7:0]                   cfg_wdata,
    input  logic [2:0]                   s_op,
    input  logic [23:0]                  s_dtc_code,
    input  logic [7:0]                   s_snapshot_count,
    input  logic [63:0]                  s_snapshot_bytes,
    input  dp_cmd_t                      cmd,
    input  logic                         out_load,
    output dp_stat_t                     stat,
    output logic                         m_outcome,
    output logic [7:0]                   m_dtc_status,
    output logic [7:0]                   m_aging_count,
    output logic [15:0]                  m_occurrence_count,
    output logic [3:0]                   m_stored_snapshot_count,
    output logic [63:0]                  m_stored_snapshot,
    output logic [5:0]                   m_active_count
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int UW = $clog2(TABLE_SLOTS + 1);
    localparam int SB = SNAPSHOT_BYTES * 8;

    logic [7:0]  thr_reg;
    logic        ready_reg;
    logic [UW-1:0] used_reg;
    logic [TABLE_SLOTS-1:0] act_reg;
    logic [23:0] code_reg [TABLE_SLOTS];
    logic [7:0]  st_reg   [TABLE_SLOTS];
    logic [7:0]  age_reg  [TABLE_SLOTS];
    logic [15:0] occ_reg  [TABLE_SLOTS];
    logic [SB-1:0] snap_reg [TABLE_SLOTS];
    logic [3:0]  slen_reg [TABLE_SLOTS];

    logic [2:0]  op_reg;
    logic [23:0] dc_reg;
    logic [7:0]  sc_reg;
    logic [63:0] sb_reg;
    logic [IW-1:0] idx_reg;
    logic        found_reg, free_reg;
    logic [IW-1:0] fidx_reg, aidx_reg;
    logic [5:0]  cnt_reg;

    logic in_used, scan_last;
    assign scan_last = ({{(32-IW){1'b0}}, idx_reg} == 32'(TABLE_SLOTS - 1));
    assign in_used   = ({{(32-IW){1'b0}}, idx_reg} < 32'(used_reg));
    assign stat.scan_last = scan_last;
    assign stat.busy_op = ready_reg && (op_reg == OP_FAILED || op_reg == OP_PASSED
                          || op_reg == OP_CLEAR_ONE || op_reg == OP_QUERY || op_reg == OP_AGE);

    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= AGING_RESET;
        else if (cfg_we) thr_reg <= cfg_wdata;
    end

    // scan: first match and first free inside used region
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_op;
            dc_reg    <= s_dtc_code;
            sc_reg    <= s_snapshot_count;
            sb_reg    <= s_snapshot_bytes;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
            fidx_reg  <= '0;
            aidx_reg  <= '0;
        end else begin
            if (cmd.step || (cmd.apply)) idx_reg <= (cmd.apply || scan_last) ? '0 : idx_reg + 1'b1;
            if (stat.busy_op && !cmd.apply && !cmd.cnt_step && in_used) begin
                if (!found_reg && act_reg[idx_reg] && code_reg[idx_reg] == dc_reg) begin
                    found_reg <= 1'b1;
                    fidx_reg  <= idx_reg;
                end
                if (!free_reg && !act_reg[idx_reg]) begin
                    free_reg <= 1'b1;
                    aidx_reg <= idx_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cnt_clear) cnt_reg <= '0;
        else if (cmd.cnt_step && ready_reg && in_used && act_reg[idx_reg])
            cnt_reg <= cnt_reg + 1'b1;
    end

    // op execution
    logic refused;
    logic clr_all;
    logic [IW-1:0] tgt;
    logic new_slot, do_fail, can_fail;
    logic [63:0] mask;
    logic [3:0]  nbytes;

    always_comb begin
        refused  = 1'b0;
        clr_all  = 1'b0;
        new_slot = 1'b0;
        do_fail  = 1'b0;
        can_fail = 1'b1;
        tgt      = fidx_reg;
        if (op_reg == OP_INIT) clr_all = 1'b1;
        else if (!ready_reg || op_reg == OP_BAD) refused = 1'b1;
        else if (op_reg == OP_CLEAR_ALL) clr_all = 1'b1;
        else if (op_reg == OP_AGE) refused = 1'b0;
        else if (dc_reg == '0) refused = 1'b1;
        else if (op_reg == OP_FAILED) begin
            if (!found_reg) begin
                new_slot = 1'b1;
                if (free_reg) tgt = aidx_reg;
                else if (32'(used_reg) < 32'(TABLE_SLOTS)) tgt = IW'(used_reg);
                else can_fail = 1'b0;
            end
            refused = !can_fail;
            do_fail = can_fail;
        end else if (op_reg == OP_CLEAR_ONE || op_reg == OP_QUERY) begin
            refused = !found_reg;
        end
        nbytes = (sc_reg > 8'(SNAPSHOT_BYTES)) ? 4'(SNAPSHOT_BYTES) : sc_reg[3:0];
        mask = '0;
        for (int b = 0; b < 8; b++)
            if (4'(b) < nbytes) mask[b*8 +: 8] = 8'hFF;
    end

    logic [7:0] st_base, st_fail;
    logic [15:0] occ_base;
    logic [7:0] age_n;
    always_comb begin
        st_base  = new_slot ? 8'h00 : st_reg[tgt];
        occ_base = new_slot ? 16'h0 : occ_reg[tgt];
        st_fail  = (st_base | ST_FAILED | ST_FAILED_CYCLE | ST_PENDING | ST_CONFIRMED
                    | ST_FAILED_CLEAR) & ~(ST_NOT_DONE_CLEAR | ST_NOT_DONE_CYCLE);
        age_n    = 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= 1'b0;
            used_reg  <= '0;
            act_reg   <= '0;
        end else if (cmd.apply) begin
            if (clr_all) begin
                ready_reg <= 1'b1;
                used_reg  <= '0;
                act_reg   <= '0;
            end else if (do_fail) begin
                act_reg[tgt] <= 1'b1;
                if (new_slot && !free_reg) used_reg <= used_reg + 1'b1;
            end else if (op_reg == OP_CLEAR_ONE && !refused) begin
                act_reg[tgt] <= 1'b0;
            end else if (op_reg == OP_AGE && ready_reg) begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    if (32'(i) < 32'(used_reg) && act_reg[i] && (st_reg[i] & ST_CONFIRMED) != 0
                        && (st_reg[i] & ST_FAILED) == 0
                        && ((age_reg[i] == AGE_MAX ? AGE_MAX : age_reg[i] + 8'd1) >= thr_reg))
                        act_reg[i] <= 1'b0;
            end
        end
    end

    // per slot payload; freed slots are rewritten at allocation, reads gated by active
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                st_reg[i] <= ST_IDLE;
                age_reg[i] <= '0;
                occ_reg[i] <= '0;
                snap_reg[i] <= '0;
                slen_reg[i] <= '0;
                code_reg[i] <= '0;
            end
        end else if (cmd.apply) begin
            if (do_fail) begin
                code_reg[tgt] <= dc_reg;
                st_reg[tgt]   <= st_fail;
                age_reg[tgt]  <= age_n;
                occ_reg[tgt]  <= (occ_base == OCC_MAX) ? OCC_MAX : occ_base + 16'd1;
                if (sc_reg != 8'd0) begin
                    snap_reg[tgt] <= SB'(sb_reg & mask);
                    slen_reg[tgt] <= nbytes;
                end else if (new_slot) begin
                    snap_reg[tgt] <= '0;
                    slen_reg[tgt] <= '0;
                end
            end else if (op_reg == OP_PASSED && ready_reg && dc_reg != '0 && found_reg) begin
                st_reg[tgt] <= st_reg[tgt] & ~(ST_FAILED | ST_NOT_DONE_CYCLE | ST_NOT_DONE_CLEAR);
            end else if (op_reg == OP_AGE && ready_reg) begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    if (32'(i) < 32'(used_reg) && act_reg[i]) begin
                        if ((st_reg[i] & ST_CONFIRMED) != 0 && (st_reg[i] & ST_FAILED) == 0)
                            age_reg[i] <= (age_reg[i] == AGE_MAX) ? AGE_MAX : age_reg[i] + 8'd1;
                        st_reg[i] <= (st_reg[i] & ~ST_FAILED_CYCLE) | ST_NOT_DONE_CYCLE;
                    end
            end
        end
    end

    // result register
    logic        r_out_reg;
    logic [7:0]  r_st_reg, r_age_reg;
    logic [15:0] r_occ_reg;
    logic [3:0]  r_len_reg;
    logic [63:0] r_snap_reg;
    logic        q_ok;
    assign q_ok = (op_reg == OP_QUERY) && ready_reg && !refused;

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            r_out_reg  <= refused;
            r_st_reg   <= q_ok ? st_reg[fidx_reg] : 8'h0;
            r_age_reg  <= q_ok ? age_reg[fidx_reg] : 8'h0;
            r_occ_reg  <= q_ok ? occ_reg[fidx_reg] : 16'h0;
            r_len_reg  <= q_ok ? slen_reg[fidx_reg] : 4'h0;
            r_snap_reg <= q_ok ? 64'(snap_reg[fidx_reg]) : 64'h0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_outcome               <= r_out_reg;
            m_dtc_status            <= r_st_reg;
            m_aging_count           <= r_age_reg;
            m_occurrence_count      <= r_occ_reg;
            m_stored_snapshot_count <= r_len_reg;
            m_stored_snapshot       <= r_snap_reg;
            m_active_count          <= cnt_reg;
        end
    end

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used_reg) <= 32'(TABLE_SLOTS))
        else $error("used slots beyond table");
    a_not_ready_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !ready_reg |-> act_reg == '0)
        else $error("active slot before init");
    a_found_active: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply && found_reg |-> act_reg[fidx_reg])
        else $error("match on inactive slot");

endmodule

@@ design/trouble_code_status_table.sv @@
// trouble code status table: top level joining controller and datapath
// ops that scan walk the slots twice (lookup scan, then count scan); init, clear all,
// bad ops and any op before init skip the lookup scan and walk the slots once
// one item at a time: a new item is taken only after the last result is loaded, which
// waits while an earlier result is still held by the receiver
// reset: synchronous active-low aresetn; table not ready until init, threshold 40
// uses tcst_pkg, tcst_ctrl, tcst_dp
module trouble_code_status_table
    import tcst_pkg::*;
#(
    parameter int TABLE_SLOTS    = TABLE_SLOTS_DEF,
    parameter int SNAPSHOT_BYTES = SNAPSHOT_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [23:0] s_dtc_code,
    input  logic [7:0]  s_snapshot_count,
    input  logic [63:0] s_snapshot_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_outcome,
    output logic [7:0]  m_dtc_status,
    output logic [7:0]  m_aging_count,
    output logic [15:0] m_occurrence_count,
    output logic [3:0]  m_stored_snapshot_count,
    output logic [63:0] m_stored_snapshot,
    output logic [5:0]  m_active_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     m_valid_i;
    logic     out_load;

    tcst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid_i),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // result register loads together with the rise of valid
    assign out_load = cmd.out_load;

    tcst_dp #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .SNAPSHOT_BYTES (SNAPSHOT_BYTES)
    ) u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cfg_we                  (cfg_we),
        .cfg_wdata               (cfg_wdata),
        .s_op                    (s_op),
        .s_dtc_code              (s_dtc_code),
        .s_snapshot_count        (s_snapshot_count),
        .s_snapshot_bytes        (s_snapshot_bytes),
        .cmd                     (cmd),
        .out_load                (out_load),
        .stat                    (stat),
        .m_outcome               (m_outcome),
        .m_dtc_status            (m_dtc_status),
        .m_aging_count           (m_aging_count),
        .m_occurrence_count      (m_occurrence_count),
        .m_stored_snapshot_count (m_stored_snapshot_count),
        .m_stored_snapshot       (m_stored_snapshot),
        .m_active_count          (m_active_count)
    );

    assign m_valid = m_valid_i;

endmodule
